@@ sv/bfa_pkg.sv @@
package bfa_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned TOTAL_W = 14;
  localparam int unsigned NUM_W   = 14;
  localparam int unsigned POS_W   = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_SETFREE = 2'd1,
    FUNC_ALLOC   = 2'd2,
    FUNC_READ    = 2'd3
  } func_e;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } scan_res_t;

endpackage

@@ sv/bfa_ram.sv @@
module bfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/bfa_scan_unit.sv @@
module bfa_scan_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned LIM_W     = 14
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [LIM_W-1:0]     base_i,
  input  logic [LIM_W-1:0]     lim_i,
  output bfa_pkg::scan_res_t   res_o
);

  import bfa_pkg::*;

  logic [LIM_W-1:0]     remaining;
  logic [6:0]           cnt;
  logic [WORD_BITS-1:0] avail;

  assign remaining = lim_i - base_i;
  assign cnt = (remaining >= LIM_W'(WORD_BITS)) ? 7'(WORD_BITS) : 7'(remaining);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = ~word_i[b] & (7'(b) < cnt);
    end
  end

  // Lowest clear bit among the bits that lie below the limit.
  always_comb begin
    res_o = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        res_o.found = 1'b1;
        res_o.pos   = POS_W'(b);
      end
    end
  end

endmodule

@@ sv/bitmap_first_free_allocator_core.sv @@
// First-fit bitmap allocator. Each input transfer yields exactly one result transfer.
// After reset the block sweeps the bitmap memory to zero, one word per cycle, and
// accepts no item until the sweep ends. A load or a set-free-count item goes from its
// acceptance straight to its result. A read of a word in range passes through a
// read-wait state while the registered read port of the bitmap memory returns the word.
// An allocate with a nonzero entry limit scans the bitmap word by word before its result.
// The single first-clear-bit search unit examines one word per cycle from the
// registered read port of the bitmap memory. The block accepts one item at a time and
// is busy until its result transfer completes. The user must write the total_entries
// register through the configuration channel only while the block is idle; the block
// itself does not enforce this.
module bitmap_first_free_allocator_core #(
  parameter int unsigned MAP_BITS  = 8192,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bfa_pkg::TOTAL_W-1:0] cfg_total_entries_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bfa_pkg::FUNC_W-1:0]  func_i,
  input  logic [bfa_pkg::INDEX_W-1:0] word_index_i,
  input  logic [bfa_pkg::DATA_W-1:0]  word_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bfa_pkg::NUM_W-1:0]   alloc_number_o,
  output logic                        alloc_ok_o,
  output logic [bfa_pkg::DATA_W-1:0]  read_word_o,
  output logic [bfa_pkg::NUM_W-1:0]   free_left_o
);

  import bfa_pkg::*;

  localparam int unsigned MAP_WORDS = (MAP_BITS / WORD_BITS > 0) ? MAP_BITS / WORD_BITS : 1;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned FW        = $clog2(MAP_BITS + 1);
  localparam int unsigned LW        = (FW > TOTAL_W) ? FW : TOTAL_W;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_RDWAIT = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [TOTAL_W-1:0]   total_q;
  logic [FW-1:0]        free_q, free_d;
  logic [LW-1:0]        lim_q, lim_d;
  logic [LW-1:0]        base_q, base_d;
  logic [AW-1:0]        scan_addr_q, scan_addr_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic                 ok_q, ok_d;
  logic [DATA_W-1:0]    rword_q, rword_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  func_e                func_in;
  logic                 in_fire;
  logic                 in_range;
  logic [AW-1:0]        in_addr;
  logic [LW-1:0]        lim_new;
  logic [LW-1:0]        next_base;
  scan_res_t            scan_res;

  bfa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  bfa_scan_unit #(
    .WORD_BITS(WORD_BITS),
    .LIM_W    (LW)
  ) u_scan (
    .word_i(ram_rdata),
    .base_i(base_q),
    .lim_i (lim_q),
    .res_o (scan_res)
  );

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_RESP);
  assign alloc_number_o = num_q;
  assign alloc_ok_o     = ok_q;
  assign read_word_o    = rword_q;
  assign free_left_o    = NUM_W'(free_q);

  assign func_in   = func_e'(func_i);
  assign in_fire   = in_valid_i & in_ready_o;
  assign in_range  = 32'(word_index_i) < 32'(MAP_WORDS);
  assign in_addr   = AW'(word_index_i);
  assign lim_new   = (32'(total_q) > 32'(MAP_BITS)) ? LW'(MAP_BITS) : LW'(total_q);
  assign next_base = base_q + LW'(WORD_BITS);

  always_comb begin
    state_d     = state_q;
    free_d      = free_q;
    lim_d       = lim_q;
    base_d      = base_q;
    scan_addr_d = scan_addr_q;
    clr_addr_d  = clr_addr_q;
    num_d       = num_q;
    ok_d        = ok_q;
    rword_d     = rword_q;
    ram_we      = 1'b0;
    ram_waddr   = scan_addr_q;
    ram_wdata   = '0;
    ram_raddr   = scan_addr_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        if (clr_addr_q == AW'(MAP_WORDS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          num_d   = '0;
          ok_d    = 1'b0;
          rword_d = '0;
          state_d = ST_RESP;
          case (func_in)
            FUNC_LOAD: begin
              ram_we    = in_range;
              ram_waddr = in_addr;
              ram_wdata = WORD_BITS'(word_data_i);
            end
            FUNC_SETFREE: begin
              free_d = (word_data_i > 32'(MAP_BITS)) ? FW'(MAP_BITS) : FW'(word_data_i);
            end
            FUNC_ALLOC: begin
              lim_d       = lim_new;
              base_d      = '0;
              scan_addr_d = '0;
              ram_raddr   = '0;
              if (lim_new != '0) begin
                state_d = ST_SCAN;
              end
            end
            FUNC_READ: begin
              ram_raddr = in_addr;
              if (in_range) begin
                state_d = ST_RDWAIT;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        rword_d = DATA_W'(ram_rdata);
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        if (scan_res.found) begin
          ram_we    = 1'b1;
          ram_waddr = scan_addr_q;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << scan_res.pos);
          num_d     = NUM_W'(base_q + LW'(scan_res.pos) + LW'(1));
          ok_d      = 1'b1;
          free_d    = (free_q != '0) ? free_q - FW'(1) : '0;
          state_d   = ST_RESP;
        end else if (next_base >= lim_q) begin
          state_d = ST_RESP;
        end else begin
          scan_addr_d = scan_addr_q + AW'(1);
          ram_raddr   = scan_addr_q + AW'(1);
          base_d      = next_base;
        end
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      free_q     <= '0;
      total_q    <= TOTAL_W'(8192);
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      free_q     <= free_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_total_entries_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q       <= lim_d;
    base_q      <= base_d;
    scan_addr_q <= scan_addr_d;
    num_q       <= num_d;
    ok_q        <= ok_d;
    rword_q     <= rword_d;
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input ready while a result is pending.");

  a_ok_has_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alloc_ok_o) |-> (alloc_number_o != '0))
    else $error("Successful allocation reported number zero.");

  a_fail_no_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !alloc_ok_o) |-> (alloc_number_o == '0))
    else $error("Nonzero number without a successful allocation.");

  a_free_only_on_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) && $past(state_q == ST_RESP) |-> $stable(free_q))
    else $error("Free counter changed while a result was waiting.");
`endif

endmodule

@@ tb/tb_bitmap_first_free_allocator_core.sv @@
module tb_bitmap_first_free_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;

  localparam int unsigned MapBits      = 8192;
  localparam int unsigned WordBits     = 32;
  localparam int unsigned MapWords     = MapBits / WordBits;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned LongHold     = 150;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems   = 150;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic              ok;
    logic [DATA_W-1:0] rword;
    logic [NUM_W-1:0]  free_left;
  } alloc_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [TOTAL_W-1:0] cfg_total_entries_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [FUNC_W-1:0]  func_i;
  logic [INDEX_W-1:0] word_index_i;
  logic [DATA_W-1:0]  word_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [NUM_W-1:0]   alloc_number_o;
  logic               alloc_ok_o;
  logic [DATA_W-1:0]  read_word_o;
  logic [NUM_W-1:0]   free_left_o;

  logic [WordBits-1:0] map_words [MapWords];
  logic [TOTAL_W-1:0]  free_count;
  logic [TOTAL_W-1:0]  total_entries;
  alloc_result_t       pending_results [$];

  bit          idle_in;
  bit          idle_out;
  bit          hold_results;
  int unsigned n_items;
  int unsigned n_alloc_ok;
  int unsigned n_alloc_fail;
  int unsigned n_cfg_writes;
  int unsigned n_errors;

  bitmap_first_free_allocator_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_total_entries_i (cfg_total_entries_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .func_i              (func_i),
    .word_index_i        (word_index_i),
    .word_data_i         (word_data_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .alloc_number_o      (alloc_number_o),
    .alloc_ok_o          (alloc_ok_o),
    .read_word_o         (read_word_o),
    .free_left_o         (free_left_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic alloc_result_t apply_request(func_e f, logic [INDEX_W-1:0] idx,
                                                  logic [DATA_W-1:0] data);
    alloc_result_t r;
    int unsigned   limit;
    r = '0;
    case (f)
      FUNC_LOAD: map_words[idx] = data;
      FUNC_SETFREE: free_count = (data > MapBits) ? TOTAL_W'(MapBits) : data[TOTAL_W-1:0];
      FUNC_ALLOC: begin
        limit = (total_entries > MapBits) ? MapBits : total_entries;
        for (int unsigned i = 0; i < limit; i++) begin
          if (!map_words[i / WordBits][i % WordBits]) begin
            map_words[i / WordBits][i % WordBits] = 1'b1;
            if (free_count != 0) free_count--;
            r.number = NUM_W'(i + 1);
            r.ok     = 1'b1;
            break;
          end
        end
      end
      default: r.rword = map_words[idx];
    endcase
    r.free_left = free_count;
    return r;
  endfunction

  task automatic send_request(func_e f, logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
    int unsigned   gap;
    alloc_result_t predicted;
    gap = idle_in ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    word_index_i <= idx;
    word_data_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_request(f, idx, data);
    pending_results.push_back(predicted);
    n_items++;
    if (f == FUNC_ALLOC) begin
      if (predicted.ok) n_alloc_ok++;
      else n_alloc_fail++;
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_total_entries(logic [TOTAL_W-1:0] value);
    wait_idle();
    cfg_valid_i         <= 1'b1;
    cfg_total_entries_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    total_entries = value;
    n_cfg_writes++;
  endtask

  task automatic send_random_request();
    int unsigned        pick;
    int unsigned        top_word;
    logic [INDEX_W-1:0] idx;
    logic [DATA_W-1:0]  data;
    func_e              f;
    top_word = (total_entries == 0) ? 0 :
               ((total_entries > MapBits ? MapBits : total_entries) - 1) / WordBits;
    if ($urandom_range(0, 4) == 0) idx = INDEX_W'($urandom_range(0, MapWords - 1));
    else idx = INDEX_W'($urandom_range(0, top_word));
    data = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      f = FUNC_ALLOC;
    end else if (pick < 70) begin
      f = FUNC_LOAD;
      case ($urandom_range(0, 3))
        0, 1: data = '1;
        2: data = ~(32'd1 << $urandom_range(0, 31));
        default: ;
      endcase
    end else if (pick < 88) begin
      f = FUNC_READ;
    end else begin
      f = FUNC_SETFREE;
      if ($urandom_range(0, 1) == 1) data = $urandom_range(0, MapBits + 1);
    end
    send_request(f, idx, data);
  endtask

  task automatic compare_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_result
    alloc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got number %0d ok %0b word %h free %0d",
                 $time, alloc_number_o, alloc_ok_o, read_word_o, free_left_o);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("alloc_number", DATA_W'(want.number), DATA_W'(alloc_number_o));
        compare_field("alloc_ok", DATA_W'(want.ok), DATA_W'(alloc_ok_o));
        compare_field("read_word", want.rword, read_word_o);
        compare_field("free_left", DATA_W'(want.free_left), DATA_W'(free_left_o));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_out ? $urandom_range(0, 5) : 0;
      if (hold_results) begin
        stall        = LongHold;
        hold_results = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("FAIL bitmap_first_free_allocator_core");
    $finish;
  end

  task automatic test_directed_requests();
    send_request(FUNC_READ, 8'h00, 32'h0);
    send_request(FUNC_READ, 8'hFF, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_SETFREE, 8'h00, 32'hFFFF_FFFF);
    send_request(FUNC_SETFREE, 8'h00, MapBits + 1);
    send_request(FUNC_SETFREE, 8'h00, MapBits);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_LOAD, 8'h00, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_LOAD, 8'hFF, 32'hAAAA_AAAA);
    send_request(FUNC_READ, 8'hFF, 32'h0);
    send_request(FUNC_LOAD, 8'h80, 32'h5555_5555);
    send_request(FUNC_READ, 8'h80, 32'h0);
    send_request(FUNC_SETFREE, 8'h00, 32'd1);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_SETFREE, 8'h00, 32'd0);
    send_request(FUNC_READ, 8'h01, 32'h0);
    send_request(FUNC_READ, 8'h00, 32'h0);
  endtask

  // The whole map is filled so that the allocates that follow scan up to the entry limit.
  task automatic test_entry_limits();
    write_total_entries('0);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    write_total_entries(TOTAL_W'(1));
    send_request(FUNC_LOAD, 8'h00, 32'h0);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    for (int w = 0; w < MapWords; w++) send_request(FUNC_LOAD, INDEX_W'(w), '1);
    write_total_entries('1);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_LOAD, 8'hFF, 32'h7FFF_FFFF);
    write_total_entries(TOTAL_W'(MapBits - 1));
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    write_total_entries(TOTAL_W'(MapBits));
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_ALLOC, 8'h00, 32'h0);
    send_request(FUNC_READ, 8'hFF, 32'h0);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_results = 1'b1;
    repeat (12) send_random_request();
    wait_idle();
    repeat (12) send_random_request();
  endtask

  task automatic test_random_traffic();
    logic [TOTAL_W-1:0] setting;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setting = TOTAL_W'(MapBits);
        1: setting = TOTAL_W'($urandom_range(1, MapBits));
        2: setting = TOTAL_W'($urandom_range(1, 96));
        3: setting = '1;
        4: setting = '0;
        5: setting = TOTAL_W'(MapBits - 1);
        6: setting = TOTAL_W'($urandom_range(MapBits + 1, (1 << TOTAL_W) - 1));
        default: setting = TOTAL_W'(1);
      endcase
      write_total_entries(setting);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 60 == 0) begin
          idle_in  = ($urandom_range(0, 3) != 0);
          idle_out = ($urandom_range(0, 3) != 0);
        end
        send_random_request();
      end
    end
    idle_in  = 1'b1;
    idle_out = 1'b1;
  endtask

  initial begin : main_sequence
    rst_ni              <= 1'b0;
    cfg_valid_i         <= 1'b0;
    cfg_total_entries_i <= '0;
    in_valid_i          <= 1'b0;
    func_i              <= FUNC_LOAD;
    word_index_i        <= '0;
    word_data_i         <= '0;
    idle_in      = 1'b1;
    idle_out     = 1'b1;
    hold_results = 1'b0;
    n_items      = 0;
    n_alloc_ok   = 0;
    n_alloc_fail = 0;
    n_cfg_writes = 0;
    n_errors     = 0;
    foreach (map_words[w]) map_words[w] = '0;
    free_count    = '0;
    total_entries = TOTAL_W'(MapBits);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_requests();
    test_entry_limits();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests: %0d allocations succeeded and %0d failed.",
             n_items, n_alloc_ok, n_alloc_fail);
    $display("The entry count was written %0d times; %0d mismatches were found.",
             n_cfg_writes, n_errors);
    if (n_errors == 0) begin
      $display("PASS bitmap_first_free_allocator_core");
    end else begin
      $display("FAIL bitmap_first_free_allocator_core");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bfa_pkg.sv
sv/bfa_ram.sv
sv/bfa_scan_unit.sv
sv/bitmap_first_free_allocator_core.sv
tb/tb_bitmap_first_free_allocator_core.sv
